// ===== rtl/spdf_pkg.sv =====
package spdf_pkg;

    // Input item opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic CFG_CRC_SEED       = 1'b0;
    localparam logic CFG_LOADER_TIMEOUT = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_LEN_MISMATCH = 3'd1;
    localparam logic [2:0] ST_TOO_BIG      = 3'd2;
    localparam logic [2:0] ST_CRC_ERROR    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN_CMD  = 3'd4;

    // Framing and command bytes
    localparam logic [7:0] SYNC_BYTE    = 8'h00;
    localparam logic [7:0] LEN_INV_MASK = 8'hFF;
    localparam logic [7:0] CMD_L        = 8'h4C;
    localparam logic [7:0] CMD_N        = 8'h4E;
    localparam logic [7:0] CMD_Z        = 8'h5A;

    // CRC and loader timer constants
    localparam logic [15:0] CRC_POLY          = 16'h8408;
    localparam logic [15:0] CRC_SEED_RST      = 16'hFFFF;
    localparam logic [9:0]  LOADER_TIMEOUT_RST = 10'h119;
    localparam logic [9:0]  TICK_MAX          = 10'd1023;

    typedef enum logic [3:0] {
        S_HUNT,
        S_LEN,
        S_LEN_INV,
        S_PAYLOAD,
        S_CRC_LO,
        S_CRC_HI,
        S_CHECK,
        S_DECIDE,
        S_EMIT_RD,
        S_EMIT_WR,
        S_STATUS
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       tick;
        logic       len_load;
        logic       pay_load;
        logic       crc_lo_load;
        logic       crc_hi_load;
        logic       pos_clear;
        logic       pos_inc;
        logic       restart;
        logic       set_loader;
        logic       emit_load;
        logic       status_load;
        logic [2:0] code;
    } t_ctl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic byte_zero;
        logic len_mismatch;
        logic len_big;
        logic len_zero;
        logic pay_last;
        logic crc_ok;
        logic cmd_ok;
        logic cmd_z;
        logic out_free;
    } t_dp_stat;

    // Reflected CCITT CRC over one byte, shifting right
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/serial_packet_deframer_crc.sv =====
// Channel  | Direction | Handshake                   | Payload
// input    | in        | i_in_valid / o_in_ready     | i_opcode, i_rx_byte
// result   | out       | o_out_valid / i_out_ready   | o_payload_byte, o_status,
//          |           |                             | o_last_of_run, o_loader_running
// config   | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Sync, header, payload, CRC bytes and ticks are each taken in one transfer.
// A finished packet passes S_CHECK and S_DECIDE to check CRC and command, then
// S_EMIT_RD and S_EMIT_WR per payload byte out (registered read of the
// single-port payload buffer) or S_STATUS for a status result; no input is taken
// during that time. Synchronous active-low reset; the payload buffer is not cleared.
// A stalled last result holds in the output register while input keeps flowing.
module serial_packet_deframer_crc #(
    parameter int BUF_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status,
    output logic        o_last_of_run,
    output logic        o_loader_running,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    spdf_pkg::t_ctl_cmd cmd;
    spdf_pkg::t_dp_stat stat;

    spdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    spdf_dpath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_payload_byte   (o_payload_byte),
        .o_status         (o_status),
        .o_last_of_run    (o_last_of_run),
        .o_loader_running (o_loader_running),
        .i_cmd            (cmd),
        .o_stat           (stat)
    );

endmodule

// ===== rtl/spdf_ctrl.sv =====
module spdf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_opcode,
    input  spdf_pkg::t_dp_stat  i_stat,
    output logic                o_in_ready,
    output spdf_pkg::t_ctl_cmd  o_cmd
);

    spdf_pkg::t_state r_state, n_state;
    logic [2:0]       r_code, n_code;
    logic             accept;
    logic             is_byte;

    assign is_byte = (i_opcode == spdf_pkg::OP_BYTE);
    assign accept  = i_in_valid && o_in_ready;

    // State and pending status code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spdf_pkg::S_HUNT;
            r_code  <= spdf_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        unique case (r_state)
            spdf_pkg::S_HUNT: begin
                if (accept && is_byte && i_stat.byte_zero) n_state = spdf_pkg::S_LEN;
            end
            spdf_pkg::S_LEN: begin
                if (accept && is_byte) n_state = spdf_pkg::S_LEN_INV;
            end
            spdf_pkg::S_LEN_INV: begin
                if (accept && is_byte) begin
                    if (i_stat.len_mismatch) begin
                        n_state = spdf_pkg::S_STATUS;
                        n_code  = spdf_pkg::ST_LEN_MISMATCH;
                    end else if (i_stat.len_big) begin
                        n_state = spdf_pkg::S_STATUS;
                        n_code  = spdf_pkg::ST_TOO_BIG;
                    end else if (i_stat.len_zero) begin
                        n_state = spdf_pkg::S_CRC_LO;
                    end else begin
                        n_state = spdf_pkg::S_PAYLOAD;
                    end
                end
            end
            spdf_pkg::S_PAYLOAD: begin
                if (accept && is_byte && i_stat.pay_last) n_state = spdf_pkg::S_CRC_LO;
            end
            spdf_pkg::S_CRC_LO: begin
                if (accept && is_byte) n_state = spdf_pkg::S_CRC_HI;
            end
            spdf_pkg::S_CRC_HI: begin
                if (accept && is_byte) n_state = spdf_pkg::S_CHECK;
            end
            spdf_pkg::S_CHECK: begin
                n_state = spdf_pkg::S_DECIDE;
            end
            spdf_pkg::S_DECIDE: begin
                if (!i_stat.crc_ok) begin
                    n_state = spdf_pkg::S_STATUS;
                    n_code  = spdf_pkg::ST_CRC_ERROR;
                end else if (i_stat.len_zero || !i_stat.cmd_ok) begin
                    n_state = spdf_pkg::S_STATUS;
                    n_code  = spdf_pkg::ST_UNKNOWN_CMD;
                end else begin
                    n_state = spdf_pkg::S_EMIT_RD;
                end
            end
            spdf_pkg::S_EMIT_RD: begin
                n_state = spdf_pkg::S_EMIT_WR;
            end
            spdf_pkg::S_EMIT_WR: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.pay_last ? spdf_pkg::S_HUNT : spdf_pkg::S_EMIT_RD;
                end
            end
            spdf_pkg::S_STATUS: begin
                if (i_stat.out_free) n_state = spdf_pkg::S_HUNT;
            end
            default: n_state = spdf_pkg::S_HUNT;
        endcase
    end

    // Commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.code = r_code;
        unique case (r_state)
            spdf_pkg::S_HUNT, spdf_pkg::S_LEN, spdf_pkg::S_LEN_INV,
            spdf_pkg::S_PAYLOAD, spdf_pkg::S_CRC_LO, spdf_pkg::S_CRC_HI: begin
                o_in_ready = 1'b1;
            end
            spdf_pkg::S_DECIDE: begin
                o_cmd.set_loader = i_stat.crc_ok && !i_stat.len_zero &&
                                   i_stat.cmd_ok && i_stat.cmd_z;
            end
            spdf_pkg::S_EMIT_WR: begin
                o_cmd.emit_load = i_stat.out_free;
                o_cmd.pos_inc   = i_stat.out_free && !i_stat.pay_last;
                o_cmd.restart   = i_stat.out_free && i_stat.pay_last;
            end
            spdf_pkg::S_STATUS: begin
                o_cmd.status_load = i_stat.out_free;
                o_cmd.restart     = i_stat.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase

        // Byte and tick transfers on the input channel
        o_cmd.tick        = accept && !is_byte;
        o_cmd.len_load    = accept && is_byte && (r_state == spdf_pkg::S_LEN);
        o_cmd.pay_load    = accept && is_byte && (r_state == spdf_pkg::S_PAYLOAD);
        o_cmd.crc_lo_load = accept && is_byte && (r_state == spdf_pkg::S_CRC_LO);
        o_cmd.crc_hi_load = accept && is_byte && (r_state == spdf_pkg::S_CRC_HI);
        o_cmd.pos_clear   = o_cmd.crc_hi_load;
    end

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spdf_pkg::S_STATUS) |-> (r_code != spdf_pkg::ST_OK))
        else $error("status state without an error code");

    a_no_input_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_load || o_cmd.status_load) |-> !o_in_ready)
        else $error("input taken while a result is being loaded");

endmodule

// ===== rtl/spdf_dpath.sv =====
module spdf_dpath #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_payload_byte,
    output logic [2:0]          o_status,
    output logic                o_last_of_run,
    output logic                o_loader_running,
    input  spdf_pkg::t_ctl_cmd  i_cmd,
    output spdf_pkg::t_dp_stat  o_stat
);

    localparam int         AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [7:0] LEN_LIMIT = 8'(BUF_DEPTH);

    logic [15:0]   r_crc_seed;
    logic [9:0]    r_timeout;
    logic [7:0]    r_len;
    logic [AW-1:0] r_pos;
    logic [15:0]   r_rx_crc;
    logic [15:0]   r_run_crc;
    logic          r_loader_flag;
    logic [9:0]    r_ticks;
    logic [9:0]    n_ticks;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [2:0]    r_out_status;
    logic          r_out_last;
    logic          r_out_loader;
    logic [7:0]    r_rd_data;
    logic [7:0]    mem [BUF_DEPTH];

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_seed <= spdf_pkg::CRC_SEED_RST;
            r_timeout  <= spdf_pkg::LOADER_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                spdf_pkg::CFG_CRC_SEED:       r_crc_seed <= i_cfg_data;
                spdf_pkg::CFG_LOADER_TIMEOUT: r_timeout  <= i_cfg_data[9:0];
                default:                      r_crc_seed <= r_crc_seed;
            endcase
        end
    end

    // Frame length, buffer position and CRC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_pos     <= '0;
            r_run_crc <= spdf_pkg::CRC_SEED_RST;
        end else begin
            if (i_cmd.len_load) r_len <= i_rx_byte;
            if (i_cmd.restart) begin
                r_pos     <= '0;
                r_run_crc <= r_crc_seed;
            end else begin
                if (i_cmd.pay_load) begin
                    r_pos     <= r_pos + AW'(1);
                    r_run_crc <= spdf_pkg::crc_byte(r_run_crc, i_rx_byte);
                end
                if (i_cmd.pos_clear) r_pos <= '0;
                if (i_cmd.pos_inc)   r_pos <= r_pos + AW'(1);
            end
        end
    end

    // Received CRC, low byte first
    always_ff @(posedge i_clk) begin
        if (i_cmd.crc_lo_load) r_rx_crc[7:0]  <= i_rx_byte;
        if (i_cmd.crc_hi_load) r_rx_crc[15:8] <= i_rx_byte;
    end

    // Payload buffer: write while receiving, registered read at the position
    always_ff @(posedge i_clk) begin
        if (i_cmd.pay_load) mem[r_pos] <= i_rx_byte;
        r_rd_data <= mem[r_pos];
    end

    // Loader flag and tick counter
    always_comb begin
        n_ticks = (r_ticks < spdf_pkg::TICK_MAX) ? r_ticks + 10'd1 : r_ticks;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loader_flag <= 1'b0;
            r_ticks       <= '0;
        end else if (i_cmd.set_loader) begin
            r_loader_flag <= 1'b1;
            r_ticks       <= '0;
        end else if (i_cmd.tick && r_loader_flag) begin
            r_ticks <= n_ticks;
            if (n_ticks > r_timeout) r_loader_flag <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load || i_cmd.status_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_byte   <= r_rd_data;
            r_out_status <= spdf_pkg::ST_OK;
            r_out_last   <= o_stat.pay_last;
            r_out_loader <= r_loader_flag;
        end else if (i_cmd.status_load) begin
            r_out_byte   <= '0;
            r_out_status <= i_cmd.code;
            r_out_last   <= 1'b1;
            r_out_loader <= r_loader_flag;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_byte   = r_out_byte;
    assign o_status         = r_out_status;
    assign o_last_of_run    = r_out_last;
    assign o_loader_running = r_out_loader;

    // Status to the controller
    always_comb begin
        o_stat.byte_zero    = (i_rx_byte == spdf_pkg::SYNC_BYTE);
        o_stat.len_mismatch = (r_len != (i_rx_byte ^ spdf_pkg::LEN_INV_MASK));
        o_stat.len_big      = (r_len >= LEN_LIMIT);
        o_stat.len_zero     = (r_len == 8'd0);
        o_stat.pay_last     = ((8'(r_pos) + 8'd1) == r_len);
        o_stat.crc_ok       = (r_rx_crc == r_run_crc);
        o_stat.cmd_ok       = (r_rd_data == spdf_pkg::CMD_L) ||
                              (r_rd_data == spdf_pkg::CMD_N) ||
                              (r_rd_data == spdf_pkg::CMD_Z);
        o_stat.cmd_z        = (r_rd_data == spdf_pkg::CMD_Z);
        o_stat.out_free     = !r_out_valid || i_out_ready;
    end

    a_flag_drop_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_loader_flag) && $past(i_rst_n)) |-> $past(i_cmd.tick))
        else $error("loader flag dropped without a tick");

    a_flag_rise_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_loader_flag) |-> (r_ticks == 10'd0))
        else $error("loader flag raised with a stale tick count");

    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != spdf_pkg::ST_OK)) |->
            (r_out_last && (r_out_byte == 8'd0)))
        else $error("status result not marked last or carries a byte");

endmodule
